### rtl/core/chained_hash_table_assert.svh
// Assertion macros for the RTL of the chained hash table.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef CHAINED_HASH_TABLE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chained hash table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chained hash table assertion failed");

`endif

### rtl/core/cht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;

  localparam int OPC_W  = 2;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int BKT_W  = 6;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OPC_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = 7'd64;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_ALLOC,
    S_ALLOC_WT,
    S_WRNODE,
    S_HEAD,
    S_LINK,
    S_NODE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic pop;
    logic fresh;
    logic take_pop;
    logic wr_node;
    logic head_rd;
    logic head_wr;
    logic follow_head;
    logic follow_link;
    logic tail_wr;
    logic unlink;
    logic found;
    logic res_set;
    res_t res;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic             clear_done;
    logic             div_done;
    logic [OPC_W-1:0] op;
    logic             has_free;
    logic             has_fresh;
    logic             head_nil;
    logic             link_nil;
    logic             key_match;
    logic             out_free;
  } stat_t;

endpackage
`default_nettype wire

### rtl/core/cht_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cht_in_if;
  logic                       valid;
  logic                       ready;
  logic [cht_pkg::OPC_W-1:0]  opcode;
  logic [cht_pkg::KEY_W-1:0]  key;
  logic signed [cht_pkg::VAL_W-1:0] value;
  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink (input valid, input opcode, input key, input value, output ready);
endinterface

interface cht_out_if;
  logic                       valid;
  logic                       ready;
  logic [cht_pkg::STAT_W-1:0] status;
  logic signed [cht_pkg::VAL_W-1:0] found_value;
  logic [cht_pkg::BKT_W-1:0]  bucket;
  modport source (output valid, output status, output found_value, output bucket, input ready);
  modport sink (input valid, input status, input found_value, input bucket, output ready);
endinterface

interface cht_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cht_pkg::CNT_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/chained_hash_table.sv
// Chained hash table: key/value store with separate chaining over a node pool.
// in_ch carries one request per beat (opcode insert, search or remove, key, value);
// out_ch returns exactly one result per request (status, found value, bucket).
// cfg_ch writes the bucket count, used as divisor of the key; write it only when
// the block is idle. cfg_ch is always ready.
// A request first forms the bit-serial remainder of the key, then runs its control
// states and walks the chain through the node memories, one node per cycle.
// One request is in flight at a time.
// After reset the bucket heads are swept to empty, one bucket a cycle;
// in_ch is not ready during that pass.
// The result sits in an output register, so the next request is accepted while
// a result waits; a stalled receiver holds the following result inside the
// block and stops further requests until out_ch takes its beat.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_table #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cht_in_if.sink     in_ch,
  cht_out_if.source  out_ch,
  cht_cfg_if.sink    cfg_ch
);
  import cht_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ch.ready = 1'b1;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  cht_dp #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_opcode       (in_ch.opcode),
    .in_key          (in_ch.key),
    .in_value        (in_ch.value),
    .cfg_valid       (cfg_ch.valid),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_found_value (out_ch.found_value),
    .out_bucket      (out_ch.bucket)
  );

endmodule
`default_nettype wire

### rtl/core/cht_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_ram #(
  parameter int W = 8,
  parameter int D = 256,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [W-1:0]       rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/cht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module cht_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire cht_pkg::stat_t stat_i,
  output cht_pkg::cmd_t       cmd_o
);
  import cht_pkg::*;

  state_t state_r, state_nxt;
  logic   is_walk_op;

  assign is_walk_op = (stat_i.op == OP_SEARCH) || (stat_i.op == OP_REMOVE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (stat_i.clear_done) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_DIV;
      S_DIV: begin
        if (stat_i.div_done) begin
          if (stat_i.op == OP_INSERT) state_nxt = S_ALLOC;
          else if (is_walk_op) state_nxt = S_HEAD;
          else state_nxt = S_DONE;
        end
      end
      S_ALLOC: begin
        if (stat_i.has_free) state_nxt = S_ALLOC_WT;
        else if (stat_i.has_fresh) state_nxt = S_WRNODE;
        else state_nxt = S_DONE;
      end
      S_ALLOC_WT: state_nxt = S_WRNODE;
      S_WRNODE:   state_nxt = S_HEAD;
      S_HEAD: begin
        if (stat_i.head_nil) state_nxt = S_DONE;
        else if (stat_i.op == OP_INSERT) state_nxt = S_LINK;
        else state_nxt = S_NODE;
      end
      S_LINK:     if (stat_i.link_nil) state_nxt = S_DONE;
      S_NODE:     if (stat_i.key_match || stat_i.link_nil) state_nxt = S_DONE;
      S_DONE:     if (stat_i.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    cmd_o.res = ST_MISS;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: cmd_o.clear = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
      end
      S_DIV: begin
        if (!stat_i.div_done) begin
          cmd_o.div = 1'b1;
        end else if (stat_i.op == OP_INSERT) begin
          cmd_o.div = 1'b0;
        end else if (is_walk_op) begin
          cmd_o.head_rd = 1'b1;
        end else begin
          cmd_o.res_set = 1'b1;
          cmd_o.res     = ST_MISS;
        end
      end
      S_ALLOC: begin
        if (stat_i.has_free) begin
          cmd_o.pop = 1'b1;
        end else if (stat_i.has_fresh) begin
          cmd_o.fresh = 1'b1;
        end else begin
          cmd_o.res_set = 1'b1;
          cmd_o.res     = ST_FULL;
        end
      end
      S_ALLOC_WT: cmd_o.take_pop = 1'b1;
      S_WRNODE:   cmd_o.wr_node = 1'b1;
      S_HEAD: begin
        if (stat_i.head_nil) begin
          cmd_o.res_set = 1'b1;
          if (stat_i.op == OP_INSERT) begin
            cmd_o.head_wr = 1'b1;
            cmd_o.res     = ST_DONE;
          end else begin
            cmd_o.res = ST_MISS;
          end
        end else begin
          cmd_o.follow_head = 1'b1;
        end
      end
      S_LINK: begin
        if (stat_i.link_nil) begin
          cmd_o.tail_wr = 1'b1;
          cmd_o.res_set = 1'b1;
          cmd_o.res     = ST_DONE;
        end else begin
          cmd_o.follow_link = 1'b1;
        end
      end
      S_NODE: begin
        if (stat_i.key_match) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res     = ST_DONE;
          if (stat_i.op == OP_SEARCH) cmd_o.found = 1'b1;
          else cmd_o.unlink = 1'b1;
        end else if (stat_i.link_nil) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res     = ST_MISS;
        end else begin
          cmd_o.follow_link = 1'b1;
        end
      end
      S_DONE: cmd_o.out_load = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/cht_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_table_assert.svh"
module cht_dp #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire cht_pkg::cmd_t               cmd_i,
  output cht_pkg::stat_t                   stat_o,
  input  wire logic [cht_pkg::OPC_W-1:0]   in_opcode,
  input  wire logic [cht_pkg::KEY_W-1:0]   in_key,
  input  wire logic [cht_pkg::VAL_W-1:0]   in_value,
  input  wire logic                        cfg_valid,
  input  wire logic [cht_pkg::CNT_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cht_pkg::STAT_W-1:0]       out_status,
  output logic [cht_pkg::VAL_W-1:0]        out_found_value,
  output logic [cht_pkg::BKT_W-1:0]        out_bucket
);
  import cht_pkg::*;

  localparam int BIW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NIW  = $clog2(NODES);
  localparam int LW   = $clog2(NODES + 1);
  localparam int KV_W = KEY_W + VAL_W;
  localparam int DCW  = $clog2(KEY_W + 1);
  localparam logic [LW-1:0]  NIL       = LW'(NODES);
  localparam logic [DCW-1:0] DIV_STEPS = DCW'(KEY_W);
  localparam logic [BIW-1:0] LAST_BKT  = BIW'(BUCKETS - 1);

  logic [CNT_W-1:0] bucket_count_r;
  logic [OPC_W-1:0] op_r;
  logic [KEY_W-1:0] key_r, sh_r;
  logic [VAL_W-1:0] value_r, fv_r;
  logic [CNT_W-1:0] div_r, rem_r;
  logic [DCW-1:0]   dcnt_r;
  logic [NIW-1:0]   n_r, cur_r;
  logic [LW-1:0]    prev_r, free_count_r, fresh_count_r;
  logic [BIW-1:0]   clr_r;
  res_t             res_r;
  logic             out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [VAL_W-1:0] out_fv_r;
  logic [BKT_W-1:0] out_bucket_r;

  logic [CNT_W-1:0] div_eff;
  logic [CNT_W:0]   trial;
  logic [BIW-1:0]   bidx;
  logic [LW-1:0]    head_rd, link_rd;
  logic [KV_W-1:0]  kv_rd;
  logic [NIW-1:0]   stack_rd, node_raddr;
  logic             prev_nil;

  logic             head_we, link_we;
  logic [BIW-1:0]   head_waddr;
  logic [LW-1:0]    head_wdata, link_wdata;
  logic [NIW-1:0]   link_waddr;

  always_comb begin
    div_eff = bucket_count_r;
    if (bucket_count_r == '0) begin
      div_eff = CNT_W'(1);
    end else if (32'(bucket_count_r) > 32'(BUCKETS)) begin
      div_eff = CNT_W'(BUCKETS);
    end
  end

  assign trial    = {rem_r, sh_r[KEY_W-1]};
  assign bidx     = BIW'(rem_r);
  assign prev_nil = (prev_r == NIL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RESET;
      dcnt_r         <= '0;
      free_count_r   <= '0;
      fresh_count_r  <= '0;
      clr_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) bucket_count_r <= cfg_data;
      if (cmd_i.load) dcnt_r <= '0;
      else if (cmd_i.div) dcnt_r <= dcnt_r + DCW'(1);
      if (cmd_i.pop) free_count_r <= free_count_r - LW'(1);
      else if (cmd_i.unlink) free_count_r <= free_count_r + LW'(1);
      if (cmd_i.fresh) fresh_count_r <= fresh_count_r + LW'(1);
      if (cmd_i.clear && clr_r != LAST_BKT) clr_r <= clr_r + BIW'(1);
      if (cmd_i.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r    <= in_opcode;
      key_r   <= in_key;
      sh_r    <= in_key;
      value_r <= in_value;
      div_r   <= div_eff;
      rem_r   <= '0;
      fv_r    <= '0;
    end
    if (cmd_i.div) begin
      sh_r <= {sh_r[KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) rem_r <= CNT_W'(trial - {1'b0, div_r});
      else rem_r <= trial[CNT_W-1:0];
    end
    if (cmd_i.fresh) n_r <= fresh_count_r[NIW-1:0];
    if (cmd_i.take_pop) n_r <= stack_rd;
    if (cmd_i.follow_head) begin
      cur_r  <= head_rd[NIW-1:0];
      prev_r <= NIL;
    end
    if (cmd_i.follow_link) begin
      cur_r  <= link_rd[NIW-1:0];
      prev_r <= LW'(cur_r);
    end
    if (cmd_i.found) fv_r <= kv_rd[VAL_W-1:0];
    if (cmd_i.res_set) res_r <= cmd_i.res;
    if (cmd_i.out_load) begin
      out_status_r <= res_r;
      out_fv_r     <= fv_r;
      out_bucket_r <= BKT_W'(rem_r);
    end
  end

  always_comb begin
    head_we    = cmd_i.clear || cmd_i.head_wr || (cmd_i.unlink && prev_nil);
    head_waddr = cmd_i.clear ? clr_r : bidx;
    if (cmd_i.clear) head_wdata = NIL;
    else if (cmd_i.head_wr) head_wdata = LW'(n_r);
    else head_wdata = link_rd;
  end

  always_comb begin
    link_we = cmd_i.wr_node || cmd_i.tail_wr || (cmd_i.unlink && !prev_nil);
    if (cmd_i.wr_node) begin
      link_waddr = n_r;
      link_wdata = NIL;
    end else if (cmd_i.tail_wr) begin
      link_waddr = cur_r;
      link_wdata = LW'(n_r);
    end else begin
      link_waddr = prev_r[NIW-1:0];
      link_wdata = link_rd;
    end
  end

  assign node_raddr = cmd_i.follow_head ? head_rd[NIW-1:0] : link_rd[NIW-1:0];

  cht_ram #(.W(LW), .D(BUCKETS)) u_head (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (cmd_i.head_rd || cmd_i.wr_node),
    .raddr (bidx),
    .rdata (head_rd)
  );

  cht_ram #(.W(LW), .D(NODES)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (cmd_i.follow_head || cmd_i.follow_link),
    .raddr (node_raddr),
    .rdata (link_rd)
  );

  cht_ram #(.W(KV_W), .D(NODES)) u_kv (
    .clk   (clk),
    .we    (cmd_i.wr_node),
    .waddr (n_r),
    .wdata ({key_r, value_r}),
    .re    (cmd_i.follow_head || cmd_i.follow_link),
    .raddr (node_raddr),
    .rdata (kv_rd)
  );

  cht_ram #(.W(NIW), .D(NODES)) u_stack (
    .clk   (clk),
    .we    (cmd_i.unlink),
    .waddr (free_count_r[NIW-1:0]),
    .wdata (cur_r),
    .re    (cmd_i.pop),
    .raddr (NIW'(free_count_r - LW'(1))),
    .rdata (stack_rd)
  );

  always_comb begin
    stat_o.clear_done = (clr_r == LAST_BKT);
    stat_o.div_done   = (dcnt_r == DIV_STEPS);
    stat_o.op         = op_r;
    stat_o.has_free   = (free_count_r != '0);
    stat_o.has_fresh  = (fresh_count_r < NIL);
    stat_o.head_nil   = (head_rd >= NIL);
    stat_o.link_nil   = (link_rd >= NIL);
    stat_o.key_match  = (kv_rd[KV_W-1 -: KEY_W] == key_r);
    stat_o.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_fv_r;
  assign out_bucket      = out_bucket_r;

  `CHT_ASSERT_NOW(a_pop_nonempty, cmd_i.pop, free_count_r != '0)
  `CHT_ASSERT_NOW(a_free_le_fresh, 1'b1, free_count_r <= fresh_count_r)
  `CHT_ASSERT_NOW(a_fresh_bound, cmd_i.fresh, fresh_count_r < NIL)
  `CHT_ASSERT_NEXT(a_load_shows, cmd_i.out_load, out_valid_r)

endmodule
`default_nettype wire
